// ===== hw/rtl/sfr_pkg.sv =====
package sfr_pkg;

    localparam int SENSOR_COUNT_DEF = 1;

    localparam int CFG_IDX_W = 8;
    localparam int CUR_W     = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q10    = 8'd3;

    localparam logic [7:0]  START_BYTE_RST  = 8'd83;
    localparam logic [7:0]  END_BYTE_RST    = 8'd69;
    localparam logic [15:0] ZERO_OFFSET_RST = 16'd512;
    localparam logic [15:0] GAIN_Q10_RST    = 16'd27049;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_LEN_ERR = 1'b1;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_LEN   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_LOW   = 3'd3,
        PH_END   = 3'd4,
        PH_DROP  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [15:0] zero_offset;
        logic [15:0] gain_q10;
    } cfg_t;

    typedef struct packed {
        logic        emit;
        logic        status;
        logic [15:0] raw_value;
        logic [31:0] frame_seq;
        logic        end_ok;
    } res_t;

endpackage

// ===== hw/rtl/sfr_conv.sv =====
module sfr_conv
(
    input  logic [15:0]                      raw_value,
    input  sfr_pkg::cfg_t                    cfg,
    output logic signed [sfr_pkg::CUR_W-1:0] current_ma
);

    localparam logic signed [23:0] CUR_MAX = 24'sd2097151;
    localparam logic signed [23:0] CUR_MIN = -24'sd2097152;

    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [23:0] quot;

    always_comb
    begin
        diff = signed'({1'b0, raw_value}) - signed'({1'b0, cfg.zero_offset});
        prod = 34'(diff) * 34'(signed'({1'b0, cfg.gain_q10}));
        // arithmetic shift floors toward minus infinity
        quot = prod[33:10];
        if (quot > CUR_MAX)
        begin
            current_ma = CUR_MAX[sfr_pkg::CUR_W-1:0];
        end
        else if (quot < CUR_MIN)
        begin
            current_ma = CUR_MIN[sfr_pkg::CUR_W-1:0];
        end
        else
        begin
            current_ma = quot[sfr_pkg::CUR_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/sfr_parser.sv =====
module sfr_parser
#(
    parameter int SENSOR_COUNT = sfr_pkg::SENSOR_COUNT_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    rx_byte,
    input  sfr_pkg::cfg_t cfg,
    output sfr_pkg::res_t res
);

    localparam int         IDX_W    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam logic [7:0] LEN_BYTE = 8'(2 * SENSOR_COUNT);
    localparam logic [IDX_W:0] LAST_CNT = (IDX_W+1)'(SENSOR_COUNT);

    sfr_pkg::phase_t   phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [15:0]       word_reg, word_next;
    logic [31:0]       seq_reg, seq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfr_pkg::PH_START;
            idx_reg   <= '0;
            seq_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            seq_reg   <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            word_reg <= word_next;
        end
    end

    always_comb
    begin
        phase_next    = sfr_pkg::PH_START;
        idx_next      = idx_reg;
        word_next     = word_reg;
        seq_next      = seq_reg;
        res.emit      = 1'b0;
        res.status    = sfr_pkg::STATUS_OK;
        res.raw_value = '0;
        res.frame_seq = '0;
        res.end_ok    = 1'b0;
        unique case (phase_reg)
            sfr_pkg::PH_LEN:
            begin
                if (rx_byte != LEN_BYTE)
                begin
                    phase_next = sfr_pkg::PH_DROP;
                    res.emit   = 1'b1;
                    res.status = sfr_pkg::STATUS_LEN_ERR;
                end
                else
                begin
                    idx_next   = '0;
                    phase_next = sfr_pkg::PH_HIGH;
                end
            end
            sfr_pkg::PH_HIGH:
            begin
                if (idx_reg == '0)
                begin
                    word_next[15:8] = rx_byte;
                end
                phase_next = sfr_pkg::PH_LOW;
            end
            sfr_pkg::PH_LOW:
            begin
                if (idx_reg == '0)
                begin
                    word_next[7:0] = rx_byte;
                end
                // other sensors' words pass through unused
                if (({1'b0, idx_reg} + 1'b1) < LAST_CNT)
                begin
                    idx_next   = idx_reg + 1'b1;
                    phase_next = sfr_pkg::PH_HIGH;
                end
                else
                begin
                    phase_next = sfr_pkg::PH_END;
                end
            end
            sfr_pkg::PH_END:
            begin
                res.emit      = 1'b1;
                res.raw_value = word_reg;
                res.frame_seq = seq_reg;
                res.end_ok    = (rx_byte == cfg.end_byte);
                seq_next      = seq_reg + 32'd1;
                phase_next    = sfr_pkg::PH_START;
            end
            sfr_pkg::PH_DROP:
            begin
                phase_next = sfr_pkg::PH_START;
            end
            default:
            begin
                if (rx_byte == cfg.start_byte)
                begin
                    phase_next = sfr_pkg::PH_LEN;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == sfr_pkg::PH_LEN && rx_byte != LEN_BYTE)
            |=> phase_reg == sfr_pkg::PH_DROP)
        else $error("length mismatch did not drop the next byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == sfr_pkg::PH_END) |=> seq_reg == $past(seq_reg) + 32'd1)
        else $error("frame count did not advance on closing byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!fire || phase_reg != sfr_pkg::PH_END) |=> seq_reg == $past(seq_reg))
        else $error("frame count moved outside closing byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, idx_reg} < LAST_CNT)
        else $error("word index past sensor count");
`endif

endmodule

// ===== hw/rtl/sensor_frame_receiver.sv =====
// A byte is captured in the input register; the parse/convert logic then loads any
// result into the output register. A stalled output holds one byte in the input
// register. Throughput: one byte per cycle while the output is not stalled.
// Reset (rst_n, async low): parser waits for a start byte, frame count zero, both
// registers empty, configuration back to 'S', 'E', offset 512, gain 27049.
module sensor_frame_receiver
#(
    parameter int SENSOR_COUNT = sfr_pkg::SENSOR_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic [15:0]                       raw_value,
    output logic signed [sfr_pkg::CUR_W-1:0]  current_ma,
    output logic [31:0]                       frame_seq,
    output logic                              end_ok
);

    sfr_pkg::cfg_t cfg_reg;

    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    logic          out_valid_reg;
    logic          status_reg;
    logic [15:0]   raw_reg;
    logic signed [sfr_pkg::CUR_W-1:0] cur_reg;
    logic [31:0]   seq_reg;
    logic          end_ok_reg;

    sfr_pkg::res_t res;
    logic signed [sfr_pkg::CUR_W-1:0] conv_cur;
    logic          out_free;
    logic          proc_fire;
    logic          load_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= sfr_pkg::START_BYTE_RST;
            cfg_reg.end_byte    <= sfr_pkg::END_BYTE_RST;
            cfg_reg.zero_offset <= sfr_pkg::ZERO_OFFSET_RST;
            cfg_reg.gain_q10    <= sfr_pkg::GAIN_Q10_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_START_BYTE:  cfg_reg.start_byte  <= cfg_data[7:0];
                sfr_pkg::CFG_END_BYTE:    cfg_reg.end_byte    <= cfg_data[7:0];
                sfr_pkg::CFG_ZERO_OFFSET: cfg_reg.zero_offset <= cfg_data;
                sfr_pkg::CFG_GAIN_Q10:    cfg_reg.gain_q10    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    sfr_parser #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (proc_fire),
        .rx_byte (byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    sfr_conv u_conv (
        .raw_value  (res.raw_value),
        .cfg        (cfg_reg),
        .current_ma (conv_cur)
    );

    // a byte that makes no result never waits on the output side
    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = in_valid_reg && (!res.emit || out_free);
    assign load_out  = proc_fire && res.emit;
    assign in_ready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
        if (load_out)
        begin
            status_reg <= res.status;
            raw_reg    <= res.raw_value;
            cur_reg    <= (res.status == sfr_pkg::STATUS_LEN_ERR) ? '0 : conv_cur;
            seq_reg    <= res.frame_seq;
            end_ok_reg <= res.end_ok;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign raw_value  = raw_reg;
    assign current_ma = cur_reg;
    assign frame_seq  = seq_reg;
    assign end_ok     = end_ok_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input held back without a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == sfr_pkg::STATUS_LEN_ERR)
            |-> (raw_reg == '0 && cur_reg == '0 && seq_reg == '0 && !end_ok_reg))
        else $error("length error result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(byte_reg)))
        else $error("stalled byte lost from input register");
`endif

endmodule

// ===== sim/tb_sensor_frame_receiver.sv =====
`timescale 1ns / 100ps

module tb_sensor_frame_receiver;

    localparam logic [7:0] LEN_OK = 8'(2 * sfr_pkg::SENSOR_COUNT_DEF);
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd200;
    localparam longint CUR_HI = (64'sd1 <<< (sfr_pkg::CUR_W - 1)) - 1;
    localparam longint CUR_LO = -(64'sd1 <<< (sfr_pkg::CUR_W - 1));
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic                             status;
        logic [15:0]                      raw_value;
        logic signed [sfr_pkg::CUR_W-1:0] current_ma;
        logic [31:0]                      frame_seq;
        logic                             end_ok;
    } frame_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [15:0]                       cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [7:0]                        rx_byte = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              status;
    logic [15:0]                       raw_value;
    logic signed [sfr_pkg::CUR_W-1:0]  current_ma;
    logic [31:0]                       frame_seq;
    logic                              end_ok;

    // Parser copy: registers and state as the block should hold them
    logic [7:0]        cfg_start = sfr_pkg::START_BYTE_RST;
    logic [7:0]        cfg_end = sfr_pkg::END_BYTE_RST;
    logic [15:0]       cfg_offset = sfr_pkg::ZERO_OFFSET_RST;
    logic [15:0]       cfg_gain = sfr_pkg::GAIN_Q10_RST;
    sfr_pkg::phase_t   parse_phase = sfr_pkg::PH_START;
    int unsigned       word_idx = 0;
    logic [15:0]       sensor0_word = '0;
    logic [31:0]       frames_done = '0;

    frame_result_t frames_pending[$];
    int            err_count = 0;
    int            in_idle_pct = 0;
    int            out_stall_pct = 0;
    int            hold_cycles = 0;
    int            quiet_cycles = 0;

    sensor_frame_receiver #(.SENSOR_COUNT(sfr_pkg::SENSOR_COUNT_DEF)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .raw_value  (raw_value),
        .current_ma (current_ma),
        .frame_seq  (frame_seq),
        .end_ok     (end_ok)
    );

    always #1 clk = ~clk;

    function automatic logic signed [sfr_pkg::CUR_W-1:0] scale_current(input logic [15:0] raw);
        longint diff;
        longint prod;
        longint q;
        diff = longint'(raw) - longint'(cfg_offset);
        prod = diff * longint'(cfg_gain);
        // arithmetic shift floors toward minus infinity
        q = prod >>> 10;
        if (q > CUR_HI)
            q = CUR_HI;
        if (q < CUR_LO)
            q = CUR_LO;
        return q[sfr_pkg::CUR_W-1:0];
    endfunction

    function automatic void apply_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [15:0] data);
        case (idx)
            sfr_pkg::CFG_START_BYTE:  cfg_start = data[7:0];
            sfr_pkg::CFG_END_BYTE:    cfg_end = data[7:0];
            sfr_pkg::CFG_ZERO_OFFSET: cfg_offset = data;
            sfr_pkg::CFG_GAIN_Q10:    cfg_gain = data;
            default:                  ;
        endcase
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        frame_result_t rec;
        case (parse_phase)
            sfr_pkg::PH_LEN:
            begin
                if (b != LEN_OK)
                begin
                    parse_phase = sfr_pkg::PH_DROP;
                    rec.status = sfr_pkg::STATUS_LEN_ERR;
                    rec.raw_value = '0;
                    rec.current_ma = '0;
                    rec.frame_seq = '0;
                    rec.end_ok = 1'b0;
                    frames_pending.push_back(rec);
                end
                else
                begin
                    word_idx = 0;
                    parse_phase = sfr_pkg::PH_HIGH;
                end
            end
            sfr_pkg::PH_HIGH:
            begin
                if (word_idx == 0)
                    sensor0_word = {b, 8'h00};
                parse_phase = sfr_pkg::PH_LOW;
            end
            sfr_pkg::PH_LOW:
            begin
                if (word_idx == 0)
                    sensor0_word[7:0] = b;
                if (word_idx + 1 < sfr_pkg::SENSOR_COUNT_DEF)
                begin
                    word_idx = (word_idx + 1) & 7;
                    parse_phase = sfr_pkg::PH_HIGH;
                end
                else
                    parse_phase = sfr_pkg::PH_END;
            end
            sfr_pkg::PH_END:
            begin
                rec.status = sfr_pkg::STATUS_OK;
                rec.raw_value = sensor0_word;
                rec.current_ma = scale_current(sensor0_word);
                rec.frame_seq = frames_done;
                rec.end_ok = (b == cfg_end);
                frames_pending.push_back(rec);
                frames_done = frames_done + 1;
                parse_phase = sfr_pkg::PH_START;
            end
            sfr_pkg::PH_DROP:
                parse_phase = sfr_pkg::PH_START;
            default:
                parse_phase = (b == cfg_start) ? sfr_pkg::PH_LEN : sfr_pkg::PH_START;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 40)
            $display("%0t: MISMATCH %s", $time, what);
    endtask

    task automatic check_result();
        frame_result_t want;
        if (frames_pending.size() == 0)
        begin
            report_mismatch("result with no frame pending");
            return;
        end
        want = frames_pending.pop_front();
        if (status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", status, want.status));
        if (raw_value !== want.raw_value)
            report_mismatch($sformatf("raw_value %h, expected %h", raw_value, want.raw_value));
        if (current_ma !== want.current_ma)
            report_mismatch($sformatf("current_ma %0d, expected %0d",
                                      current_ma, want.current_ma));
        if (frame_seq !== want.frame_seq)
            report_mismatch($sformatf("frame_seq %0d, expected %0d", frame_seq, want.frame_seq));
        if (end_ok !== want.end_ok)
            report_mismatch($sformatf("end_ok %b, expected %b", end_ok, want.end_ok));
    endtask

    // Predict before checking so a same-edge result would still find its entry
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte);
            if (out_valid && out_ready)
                check_result();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles--;
        end
        else
            out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop the request line and wait out every pending frame plus the input stage
    task automatic wait_frames_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frames_pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [7:0] sb, input logic [7:0] eb,
                                input logic [15:0] off, input logic [15:0] gain);
        wait_frames_drained();
        // upper data bits are don't-care for the byte registers
        write_reg(sfr_pkg::CFG_START_BYTE, {8'($urandom), sb});
        write_reg(sfr_pkg::CFG_END_BYTE, {8'($urandom), eb});
        write_reg(sfr_pkg::CFG_ZERO_OFFSET, off);
        write_reg(sfr_pkg::CFG_GAIN_Q10, gain);
    endtask

    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames; some noise, bad lengths and bad closing bytes
    task automatic send_random_frame();
        logic [7:0] len;
        if ($urandom_range(99) < 6)
        begin
            send_byte(8'($urandom));
            return;
        end
        send_byte(cfg_start);
        len = ($urandom_range(99) < 85) ? LEN_OK : 8'($urandom);
        send_byte(len);
        if (len != LEN_OK)
        begin
            send_byte($urandom_range(1) ? cfg_start : 8'($urandom));
            return;
        end
        send_byte(pick_data_byte());
        send_byte(pick_data_byte());
        send_byte(($urandom_range(99) < 85) ? cfg_end : 8'($urandom));
    endtask

    task automatic test_directed_frames();
        logic [7:0] stream[] = {
            sfr_pkg::START_BYTE_RST, LEN_OK, 8'h00, 8'h00, sfr_pkg::END_BYTE_RST,
            8'hFF, sfr_pkg::START_BYTE_RST, LEN_OK, 8'hFF, 8'hFF, 8'h00,
            sfr_pkg::START_BYTE_RST, sfr_pkg::START_BYTE_RST, sfr_pkg::START_BYTE_RST,
            sfr_pkg::START_BYTE_RST, 8'hFF, 8'h00,
            sfr_pkg::START_BYTE_RST, 8'h00, sfr_pkg::END_BYTE_RST,
            sfr_pkg::START_BYTE_RST, LEN_OK, 8'h02, 8'h00, sfr_pkg::END_BYTE_RST
        };
        in_idle_pct = 0;
        out_stall_pct = 0;
        foreach (stream[i])
            send_byte(stream[i]);
        wait_frames_drained();
    endtask

    task automatic test_random_traffic(input int n_frames, input int idle_pct,
                                       input int stall_pct, input bit new_regs);
        if (new_regs)
            program_regs(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        in_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        repeat (n_frames)
            send_random_frame();
        wait_frames_drained();
    endtask

    task automatic test_register_extremes();
        // an out-of-range index must leave every register untouched
        write_reg(CFG_IDX_UNUSED, 16'($urandom));
        program_regs(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        test_random_traffic(20, 0, 28, 1'b0);
        program_regs(8'hFF, 8'h00, 16'h0000, 16'hFFFF);
        test_random_traffic(20, 28, 0, 1'b0);
        program_regs(LEN_OK, LEN_OK, 16'h0000, 16'h0000);
        test_random_traffic(20, 0, 0, 1'b0);
        write_reg(CFG_IDX_UNUSED, 16'hFFFF);
        program_regs(sfr_pkg::START_BYTE_RST, sfr_pkg::END_BYTE_RST, 16'h8000, 16'h0001);
        test_random_traffic(20, 28, 28, 1'b0);
    endtask

    task automatic test_backpressure();
        in_idle_pct = 0;
        out_stall_pct = 0;
        @(posedge clk);
        // hold results off while requests keep coming so the input stalls
        hold_cycles = 80;
        repeat (20)
            send_random_frame();
        wait_frames_drained();
        hold_cycles = 40;
        out_stall_pct = 55;
        repeat (20)
            send_random_frame();
        wait_frames_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_random_traffic(66, 0, 0, 1'b0);
        test_register_extremes();
        test_random_traffic(66, 55, 0, 1'b1);
        test_random_traffic(66, 0, 55, 1'b1);
        test_random_traffic(66, 28, 28, 1'b1);
        test_backpressure();

        wait_frames_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_conv.sv
hw/rtl/sfr_parser.sv
hw/rtl/sensor_frame_receiver.sv
sim/tb_sensor_frame_receiver.sv
